>>> design/pte_pkg.sv
// pte_pkg: shared types, constants and helpers for the planar twist estimator
// used by pte_alu and planar_twist_estimator_ema_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pte_pkg;

   localparam logic [1:0] ALU_MUL = 2'd0;
   localparam logic [1:0] ALU_DIV = 2'd1;
   localparam logic [1:0] ALU_RND = 2'd2;

   localparam logic CSR_FILTER_ALPHA = 1'b0;
   localparam logic CSR_MAX_INTERVAL = 1'b1;

   localparam logic [31:0] SIN_A1    = 32'd1686629713;
   localparam logic [31:0] SIN_A3    = 32'd693598669;
   localparam logic [31:0] SIN_A5    = 32'd85569309;
   localparam logic [31:0] SIN_A7    = 32'd5026995;
   localparam logic [31:0] SIN_A9    = 32'd172272;
   localparam logic [30:0] Q30_ONE   = 31'd1073741824;
   localparam logic [31:0] Q24_ONE   = 32'd16777216;
   localparam logic [31:0] PI_Q24    = 32'd52707179;
   localparam logic [31:0] TWO_PI_E6 = 32'd6283185;
   localparam logic [31:0] US_PER_S  = 32'd1000000;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;

   typedef struct packed {
      logic               start;
      logic [1:0]         op;
      logic signed [63:0] a;
      logic signed [32:0] b;
      logic [5:0]         shamt;
   } alu_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] result;
   } alu_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sin_coef(input logic [1:0] j);
      logic [31:0] c;
      case (j)
         2'd0:    c = SIN_A7;
         2'd1:    c = SIN_A5;
         2'd2:    c = SIN_A3;
         default: c = SIN_A1;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> design/pte_alu.sv
// pte_alu: shared sign-magnitude unit: 8-bit-per-step multiply, restoring
// divide with round half away from zero, rounded shift; uses pte_pkg
`timescale 1ns / 1ps
`default_nettype none

module pte_alu (
   input  wire                  clock,
   input  wire                  reset,
   input  wire pte_pkg::alu_req_type req,
   output pte_pkg::alu_rsp_type rsp
);
   import pte_pkg::*;

   localparam logic [1:0] AS_IDLE = 2'd0;
   localparam logic [1:0] AS_RUN  = 2'd1;
   localparam logic [1:0] AS_FIN  = 2'd2;
   localparam logic [5:0] MUL_LAST = 6'd3;
   localparam logic [5:0] DIV_LAST = 6'd63;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic        neg_ff, neg_in;
   logic [5:0]  shamt_ff, shamt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic signed [63:0] res_ff, res_in;
   logic        done_ff, done_in;

   logic [63:0] abs_a;
   logic [32:0] abs_b;
   logic [71:0] mul_part;
   logic [32:0] shifted;
   logic [63:0] rounded;

   always_comb begin
      abs_a    = req.a[63] ? 64'(-req.a) : 64'(req.a);
      abs_b    = req.b[32] ? 33'(-req.b) : 33'(req.b);
      mul_part = 72'(num_ff) * 72'(den_ff[7:0]);
      shifted  = {rem_ff, num_ff[63]};
      rounded  = num_ff + (64'd1 << (shamt_ff - 6'd1));

      state_in = state_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      shamt_in = shamt_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         AS_IDLE: begin
            if (req.start) begin
               op_in    = req.op;
               neg_in   = (req.op == ALU_RND) ? req.a[63] : (req.a[63] ^ req.b[32]);
               den_in   = abs_b[31:0];
               num_in   = (req.op == ALU_DIV) ? abs_a + 64'(abs_b[31:1]) : abs_a;
               shamt_in = req.shamt;
               cnt_in   = '0;
               acc_in   = '0;
               rem_in   = '0;
               state_in = AS_RUN;
            end
         end
         AS_RUN: begin
            case (op_ff)
               ALU_MUL: begin
                  acc_in = acc_ff + mul_part[63:0];
                  num_in = num_ff << 8;
                  den_in = den_ff >> 8;
                  cnt_in = cnt_ff + 6'd1;
                  if (cnt_ff == MUL_LAST) state_in = AS_FIN;
               end
               ALU_DIV: begin
                  if (shifted >= {1'b0, den_ff}) begin
                     rem_in = 32'(shifted - {1'b0, den_ff});
                     acc_in = {acc_ff[62:0], 1'b1};
                  end else begin
                     rem_in = shifted[31:0];
                     acc_in = {acc_ff[62:0], 1'b0};
                  end
                  num_in = num_ff << 1;
                  cnt_in = cnt_ff + 6'd1;
                  if (cnt_ff == DIV_LAST) state_in = AS_FIN;
               end
               default: begin
                  acc_in   = rounded >> shamt_ff;
                  state_in = AS_FIN;
               end
            endcase
         end
         AS_FIN: begin
            res_in   = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
            done_in  = 1'b1;
            state_in = AS_IDLE;
         end
         default: state_in = AS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff    <= op_in;
      neg_ff   <= neg_in;
      shamt_ff <= shamt_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      res_ff   <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

`default_nettype wire

>>> design/planar_twist_estimator_ema_core.sv
// planar_twist_estimator_ema_core: planar twist from timestamped poses with
// exponential smoothing; sequencer around pte_alu; uses pte_pkg
// a usable step with a yaw change runs 43 multiplies, 8 rounding shifts and 4
// divides on the shared unit; the q and p steps are skipped with no yaw change and
// the filter steps are skipped while the filter is being seeded; a first pose or a
// rejected step goes from the check straight to the result; one pose at a time,
// next pose taken in the cycle after the result is registered; synchronous
// active-high reset clears the control state, the filter and the CSRs to defaults
`timescale 1ns / 1ps
`default_nettype none

module planar_twist_estimator_ema_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,  // pose_x, pose_y, pose_yaw, stamp_us
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [95:0]  rsp_tdata,  // vel_forward, vel_lateral, yaw_rate
   output logic         rsp_tuser,  // velocity_valid
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire          csr_index,
   input  wire  [31:0]  csr_data
);
   import pte_pkg::*;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_CHECK    = 5'd1;
   localparam logic [4:0] ST_SIN_SQ   = 5'd2;
   localparam logic [4:0] ST_SIN_POLY = 5'd3;
   localparam logic [4:0] ST_SIN_X    = 5'd4;
   localparam logic [4:0] ST_BX_A     = 5'd5;
   localparam logic [4:0] ST_BX_B     = 5'd6;
   localparam logic [4:0] ST_BX_R     = 5'd7;
   localparam logic [4:0] ST_BY_A     = 5'd8;
   localparam logic [4:0] ST_BY_B     = 5'd9;
   localparam logic [4:0] ST_BY_R     = 5'd10;
   localparam logic [4:0] ST_Q_M      = 5'd11;
   localparam logic [4:0] ST_Q_R      = 5'd12;
   localparam logic [4:0] ST_P_M      = 5'd13;
   localparam logic [4:0] ST_P_D      = 5'd14;
   localparam logic [4:0] ST_FWD_A    = 5'd15;
   localparam logic [4:0] ST_FWD_B    = 5'd16;
   localparam logic [4:0] ST_FWD_R    = 5'd17;
   localparam logic [4:0] ST_LAT_A    = 5'd18;
   localparam logic [4:0] ST_LAT_B    = 5'd19;
   localparam logic [4:0] ST_LAT_R    = 5'd20;
   localparam logic [4:0] ST_RATE_M   = 5'd21;
   localparam logic [4:0] ST_RATE_D   = 5'd22;
   localparam logic [4:0] ST_FLT_A    = 5'd23;
   localparam logic [4:0] ST_FLT_B    = 5'd24;
   localparam logic [4:0] ST_FLT_R    = 5'd25;
   localparam logic [4:0] ST_OUT      = 5'd26;

   logic [4:0] state_ff, state_in;
   logic       issued_ff, issued_in;

   logic signed [31:0] in_x_ff, in_x_in, in_y_ff, in_y_in;
   logic [15:0]        in_yaw_ff, in_yaw_in;
   logic [47:0]        in_stamp_ff, in_stamp_in;

   logic signed [31:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [15:0]        last_heading_ff, last_heading_in;
   logic [47:0]        last_stamp_ff, last_stamp_in;
   logic               have_last_ff, have_last_in;
   logic signed [31:0] sm_ff [3];
   logic signed [31:0] sm_in [3];
   logic               have_sm_ff, have_sm_in;

   logic [16:0] alpha_ff, alpha_in;
   logic [31:0] max_int_ff, max_int_in;

   logic [31:0]        dt_ff, dt_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [16:0] d_ff, d_in;
   logic signed [31:0] trig_ff [4];
   logic signed [31:0] trig_in [4];
   logic [1:0]         k_ff, k_in, j_ff, j_in, i_ff, i_in;
   logic [30:0]        x2_ff, x2_in;
   logic [31:0]        r_ff, r_in;
   logic signed [63:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [35:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [27:0] q_ff, q_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [36:0] fwd_ff, fwd_in, lat_ff, lat_in;
   logic signed [31:0] raw_ff [3];
   logic signed [31:0] raw_in [3];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic [47:0]        dt_full;
   logic               step_ok;
   logic [15:0]        diff16;
   logic [17:0]        head_ang, half_ang, ang;
   logic [16:0]        f17;
   logic [30:0]        sx;
   logic [31:0]        sin_mag;
   logic [30:0]        sin_clamp;
   logic [16:0]        alpha_eff;
   logic               op_state;
   logic signed [63:0] res;

   pte_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   always_comb begin
      res       = alu_rsp.result;
      dt_full   = in_stamp_ff - last_stamp_ff;
      step_ok   = (in_stamp_ff > last_stamp_ff) && (dt_full <= {16'd0, max_int_ff});
      diff16    = in_yaw_ff - last_heading_ff;
      head_ang  = {last_heading_ff, 2'b00};
      half_ang  = {d_ff, 1'b0};
      case (k_ff)
         2'd0:    ang = head_ang + 18'd65536;
         2'd1:    ang = head_ang;
         2'd2:    ang = half_ang + 18'd65536;
         default: ang = half_ang;
      endcase
      f17       = ang[16] ? 17'd65536 - {1'b0, ang[15:0]} : {1'b0, ang[15:0]};
      sx        = {f17, 14'd0};
      sin_mag   = res[61:30];
      sin_clamp = (sin_mag > 32'(Q30_ONE)) ? Q30_ONE : sin_mag[30:0];
      alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      op_state  = (state_ff != ST_IDLE) && (state_ff != ST_CHECK) && (state_ff != ST_OUT);
   end

   always_comb begin
      state_in        = state_ff;
      in_x_in         = in_x_ff;
      in_y_in         = in_y_ff;
      in_yaw_in       = in_yaw_ff;
      in_stamp_in     = in_stamp_ff;
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;
      last_heading_in = last_heading_ff;
      last_stamp_in   = last_stamp_ff;
      have_last_in    = have_last_ff;
      sm_in           = sm_ff;
      have_sm_in      = have_sm_ff;
      alpha_in        = alpha_ff;
      max_int_in      = max_int_ff;
      dt_in           = dt_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      d_in            = d_ff;
      trig_in         = trig_ff;
      k_in            = k_ff;
      j_in            = j_ff;
      i_in            = i_ff;
      x2_in           = x2_ff;
      r_in            = r_ff;
      pa_in           = pa_ff;
      pb_in           = pb_ff;
      bx_in           = bx_ff;
      by_in           = by_ff;
      q_in            = q_ff;
      p_in            = p_ff;
      fwd_in          = fwd_ff;
      lat_in          = lat_ff;
      raw_in          = raw_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_user_in     = rsp_user_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      alu_req.start = 1'b0;
      alu_req.op    = ALU_MUL;
      alu_req.a     = '0;
      alu_req.b     = '0;
      alu_req.shamt = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_FILTER_ALPHA: alpha_in   = csr_data[16:0];
            CSR_MAX_INTERVAL: max_int_in = csr_data;
            default:          alpha_in   = alpha_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               in_x_in     = req_tdata[31:0];
               in_y_in     = req_tdata[63:32];
               in_yaw_in   = req_tdata[79:64];
               in_stamp_in = req_tdata[127:80];
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!have_last_ff) begin
               state_in = ST_OUT;
            end else if (!step_ok) begin
               have_sm_in = 1'b0;
               state_in   = ST_OUT;
            end else begin
               dt_in    = dt_full[31:0];
               dx_in    = {in_x_ff[31], in_x_ff} - {last_x_ff[31], last_x_ff};
               dy_in    = {in_y_ff[31], in_y_ff} - {last_y_ff[31], last_y_ff};
               d_in     = (diff16 > 16'd32768) ? {1'b1, diff16} : {1'b0, diff16};
               p_in     = $signed(Q24_ONE);
               q_in     = '0;
               k_in     = '0;
               state_in = ST_SIN_SQ;
            end
         end
         ST_SIN_SQ: begin
            alu_req.a = $signed(64'(sx));
            alu_req.b = $signed(33'(sx));
            if (alu_rsp.done) begin
               x2_in    = res[60:30];
               r_in     = SIN_A9;
               j_in     = '0;
               state_in = ST_SIN_POLY;
            end
         end
         ST_SIN_POLY: begin
            alu_req.a = $signed(64'(r_ff));
            alu_req.b = $signed(33'(x2_ff));
            if (alu_rsp.done) begin
               r_in = sin_coef(j_ff) - res[61:30];
               j_in = j_ff + 2'd1;
               if (j_ff == 2'd3) state_in = ST_SIN_X;
            end
         end
         ST_SIN_X: begin
            alu_req.a = $signed(64'(r_ff));
            alu_req.b = $signed(33'(sx));
            if (alu_rsp.done) begin
               trig_in[k_ff] = ang[17] ? -$signed({1'b0, sin_clamp}) : $signed({1'b0, sin_clamp});
               k_in          = k_ff + 2'd1;
               state_in      = (k_ff == 2'd3) ? ST_BX_A : ST_SIN_SQ;
            end
         end
         ST_BX_A: begin
            alu_req.a = 64'(dx_ff);
            alu_req.b = 33'(trig_ff[0]);
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = ST_BX_B;
            end
         end
         ST_BX_B: begin
            alu_req.a = 64'(dy_ff);
            alu_req.b = 33'(trig_ff[1]);
            if (alu_rsp.done) begin
               pb_in    = res;
               state_in = ST_BX_R;
            end
         end
         ST_BX_R: begin
            alu_req.op    = ALU_RND;
            alu_req.a     = pa_ff + pb_ff;
            alu_req.shamt = 6'd30;
            if (alu_rsp.done) begin
               bx_in    = res[35:0];
               state_in = ST_BY_A;
            end
         end
         ST_BY_A: begin
            alu_req.a = 64'(dy_ff);
            alu_req.b = 33'(trig_ff[0]);
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = ST_BY_B;
            end
         end
         ST_BY_B: begin
            alu_req.a = 64'(dx_ff);
            alu_req.b = 33'(trig_ff[1]);
            if (alu_rsp.done) begin
               pb_in    = res;
               state_in = ST_BY_R;
            end
         end
         ST_BY_R: begin
            alu_req.op    = ALU_RND;
            alu_req.a     = pa_ff - pb_ff;
            alu_req.shamt = 6'd30;
            if (alu_rsp.done) begin
               by_in    = res[35:0];
               state_in = (d_ff == 17'sd0) ? ST_FWD_A : ST_Q_M;
            end
         end
         ST_Q_M: begin
            alu_req.a = $signed(64'(PI_Q24));
            alu_req.b = 33'(d_ff);
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = ST_Q_R;
            end
         end
         ST_Q_R: begin
            alu_req.op    = ALU_RND;
            alu_req.a     = pa_ff;
            alu_req.shamt = 6'd16;
            if (alu_rsp.done) begin
               q_in     = res[27:0];
               state_in = ST_P_M;
            end
         end
         ST_P_M: begin
            alu_req.a = 64'(q_ff);
            alu_req.b = 33'(trig_ff[2]);
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = (trig_ff[3] == 32'sd0) ? ST_FWD_A : ST_P_D;
            end
         end
         ST_P_D: begin
            alu_req.op = ALU_DIV;
            alu_req.a  = pa_ff;
            alu_req.b  = 33'(trig_ff[3]);
            if (alu_rsp.done) begin
               p_in     = res[31:0];
               state_in = ST_FWD_A;
            end
         end
         ST_FWD_A: begin
            alu_req.a = 64'(bx_ff);
            alu_req.b = 33'(p_ff);
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = ST_FWD_B;
            end
         end
         ST_FWD_B: begin
            alu_req.a = 64'(by_ff);
            alu_req.b = 33'(q_ff);
            if (alu_rsp.done) begin
               pb_in    = res;
               state_in = ST_FWD_R;
            end
         end
         ST_FWD_R: begin
            alu_req.op    = ALU_RND;
            alu_req.a     = pa_ff + pb_ff;
            alu_req.shamt = 6'd24;
            if (alu_rsp.done) begin
               fwd_in   = res[36:0];
               state_in = ST_LAT_A;
            end
         end
         ST_LAT_A: begin
            alu_req.a = 64'(by_ff);
            alu_req.b = 33'(p_ff);
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = ST_LAT_B;
            end
         end
         ST_LAT_B: begin
            alu_req.a = 64'(bx_ff);
            alu_req.b = 33'(q_ff);
            if (alu_rsp.done) begin
               pb_in    = res;
               state_in = ST_LAT_R;
            end
         end
         ST_LAT_R: begin
            alu_req.op    = ALU_RND;
            alu_req.a     = pa_ff - pb_ff;
            alu_req.shamt = 6'd24;
            if (alu_rsp.done) begin
               lat_in   = res[36:0];
               i_in     = '0;
               state_in = ST_RATE_M;
            end
         end
         ST_RATE_M: begin
            case (i_ff)
               2'd0:    alu_req.a = 64'(fwd_ff);
               2'd1:    alu_req.a = 64'(lat_ff);
               default: alu_req.a = 64'(d_ff);
            endcase
            alu_req.b = (i_ff == 2'd2) ? $signed(33'(TWO_PI_E6)) : $signed(33'(US_PER_S));
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = ST_RATE_D;
            end
         end
         ST_RATE_D: begin
            alu_req.op = ALU_DIV;
            alu_req.a  = pa_ff;
            alu_req.b  = $signed({1'b0, dt_ff});
            if (alu_rsp.done) begin
               raw_in[i_ff] = sat32(res);
               if (i_ff != 2'd2) begin
                  i_in     = i_ff + 2'd1;
                  state_in = ST_RATE_M;
               end else if (have_sm_ff) begin
                  i_in     = '0;
                  state_in = ST_FLT_A;
               end else begin
                  sm_in[0]   = raw_ff[0];
                  sm_in[1]   = raw_ff[1];
                  sm_in[2]   = sat32(res);
                  have_sm_in = 1'b1;
                  state_in   = ST_OUT;
               end
            end
         end
         ST_FLT_A: begin
            alu_req.a = 64'(raw_ff[i_ff]);
            alu_req.b = $signed(33'(alpha_eff));
            if (alu_rsp.done) begin
               pa_in    = res;
               state_in = ST_FLT_B;
            end
         end
         ST_FLT_B: begin
            alu_req.a = 64'(sm_ff[i_ff]);
            alu_req.b = $signed(33'(ALPHA_ONE - alpha_eff));
            if (alu_rsp.done) begin
               pb_in    = res;
               state_in = ST_FLT_R;
            end
         end
         ST_FLT_R: begin
            alu_req.op    = ALU_RND;
            alu_req.a     = pa_ff + pb_ff;
            alu_req.shamt = 6'd16;
            if (alu_rsp.done) begin
               sm_in[i_ff] = sat32(res);
               i_in        = i_ff + 2'd1;
               state_in    = (i_ff == 2'd2) ? ST_OUT : ST_FLT_A;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = have_sm_ff ? {sm_ff[2], sm_ff[1], sm_ff[0]} : 96'd0;
               rsp_user_in     = have_sm_ff;
               last_x_in       = in_x_ff;
               last_y_in       = in_y_ff;
               last_heading_in = in_yaw_ff;
               last_stamp_in   = in_stamp_ff;
               have_last_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      alu_req.start = op_state && !issued_ff;
      issued_in     = alu_rsp.done ? 1'b0 : (issued_ff || alu_req.start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         have_last_ff <= 1'b0;
         have_sm_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= 17'd22938;
         max_int_ff   <= 32'd1000000;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         have_last_ff <= have_last_in;
         have_sm_ff   <= have_sm_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_ff     <= alpha_in;
         max_int_ff   <= max_int_in;
      end
      in_x_ff         <= in_x_in;
      in_y_ff         <= in_y_in;
      in_yaw_ff       <= in_yaw_in;
      in_stamp_ff     <= in_stamp_in;
      last_x_ff       <= last_x_in;
      last_y_ff       <= last_y_in;
      last_heading_ff <= last_heading_in;
      last_stamp_ff   <= last_stamp_in;
      sm_ff           <= sm_in;
      dt_ff           <= dt_in;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      d_ff            <= d_in;
      trig_ff         <= trig_in;
      k_ff            <= k_in;
      j_ff            <= j_in;
      i_ff            <= i_in;
      x2_ff           <= x2_in;
      r_ff            <= r_in;
      pa_ff           <= pa_in;
      pb_ff           <= pb_in;
      bx_ff           <= bx_in;
      by_ff           <= by_in;
      q_ff            <= q_in;
      p_ff            <= p_in;
      fwd_ff          <= fwd_in;
      lat_ff          <= lat_in;
      raw_ff          <= raw_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_user_ff     <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire
